// ----- hw/rtl/rmor_pkg.sv -----
package rmor_pkg;

    localparam int RING_BYTES_DEF  = 4096;
    localparam int NUM_CURSORS_DEF = 4;
    localparam int MAX_PULL_DEF    = 64;

    // command queue between front and back, result buffer at the output
    localparam int CQ_DEPTH = 2;
    localparam int CQ_PTR_W = 1;
    localparam int OB_DEPTH = 2;
    localparam int OB_PTR_W = 1;

    localparam logic [2:0] CMD_EMIT  = 3'd0;
    localparam logic [2:0] CMD_SNAP  = 3'd1;
    localparam logic [2:0] CMD_PULL  = 3'd2;
    localparam logic [2:0] CMD_SKIP  = 3'd3;
    localparam logic [2:0] CMD_STATS = 3'd4;

    typedef enum logic [2:0] {
        OP_EMIT,
        OP_SNAP,
        OP_PULL,
        OP_SKIP,
        OP_STATS,
        OP_BADPULL
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic [1:0] id;
        logic [6:0] maxb;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cq_head_t;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic        byte_valid;
        logic        last_of_run;
        logic [6:0]  taken_count;
        logic [31:0] drops_so_far;
        logic [12:0] used_bytes;
        logic [16:0] ring_capacity;
    } res_t;

    typedef struct packed {
        logic push;
        res_t res;
    } ob_push_t;

    typedef struct packed {
        logic [1:0] level;
        logic       pop;
    } ob_stat_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LAG,
        BK_CATCH,
        BK_STREAM,
        BK_RESULT
    } bk_state_t;

endpackage

// ----- hw/rtl/rmor_front.sv -----
module rmor_front import rmor_pkg::*; #(
    parameter int NUM_CURSORS = NUM_CURSORS_DEF,
    parameter int MAX_PULL    = MAX_PULL_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_command,
    input  logic [7:0] s_data_byte,
    input  logic [1:0] s_cursor_id,
    input  logic [6:0] s_max_bytes,
    output cq_head_t   cq_head,
    input  logic       cq_pop
);

    cmd_t                cq_mem [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [1:0]          level_reg, level_next;

    cmd_t cmd_in;
    logic keep;
    logic id_ok;
    logic push;

    // classify: drop unused codes and snapshot/skip on a missing cursor
    always_comb begin
        id_ok       = int'(s_cursor_id) < NUM_CURSORS;
        cmd_in.data = s_data_byte;
        cmd_in.id   = s_cursor_id;
        cmd_in.maxb = (s_max_bytes > 7'(MAX_PULL)) ? 7'(MAX_PULL) : s_max_bytes;
        cmd_in.op   = OP_EMIT;
        keep        = 1'b0;
        case (s_command)
            CMD_EMIT: begin
                cmd_in.op = OP_EMIT;
                keep      = 1'b1;
            end
            CMD_SNAP: begin
                cmd_in.op = OP_SNAP;
                keep      = id_ok;
            end
            CMD_PULL: begin
                cmd_in.op = id_ok ? OP_PULL : OP_BADPULL;
                keep      = 1'b1;
            end
            CMD_SKIP: begin
                cmd_in.op = OP_SKIP;
                keep      = id_ok;
            end
            CMD_STATS: begin
                cmd_in.op = OP_STATS;
                keep      = 1'b1;
            end
            default: begin
                cmd_in.op = OP_EMIT;
                keep      = 1'b0;
            end
        endcase
    end

    assign s_ready       = (level_reg != 2'(CQ_DEPTH));
    assign push          = s_valid && s_ready && keep;
    assign cq_head.valid = (level_reg != 2'd0);
    assign cq_head.cmd   = cq_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = cq_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        level_next  = level_reg + {1'b0, push} - {1'b0, cq_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            cq_mem[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// ----- hw/rtl/rmor_back.sv -----
module rmor_back import rmor_pkg::*; #(
    parameter int RING_BYTES  = RING_BYTES_DEF,
    parameter int NUM_CURSORS = NUM_CURSORS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  cq_head_t cq_head,
    output logic     cq_pop,
    input  ob_stat_t ob_stat,
    output ob_push_t ob_push
);

    localparam int SLOT_W = $clog2(RING_BYTES);
    localparam int CIDX_W = (NUM_CURSORS > 1) ? $clog2(NUM_CURSORS) : 1;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_BYTES - 1);
    localparam longint unsigned WRAP_REM = 64'h1_0000_0000 % RING_BYTES;
    localparam logic [SLOT_W:0] WRAP_REM_EXT = (SLOT_W + 1)'(WRAP_REM);
    localparam logic [SLOT_W:0] RING_EXT = (SLOT_W + 1)'(RING_BYTES);
    localparam logic [31:0] RING_W32 = 32'(RING_BYTES);

    bk_state_t state_reg, state_next;

    logic [31:0]       wp_reg;
    logic [SLOT_W-1:0] wslot_reg;
    logic [31:0]       cpos_reg  [NUM_CURSORS];
    logic [31:0]       cdrop_reg [NUM_CURSORS];
    logic [SLOT_W-1:0] cslot_reg [NUM_CURSORS];

    logic [CIDX_W-1:0] id_reg;
    logic [6:0]        maxb_reg;
    logic [31:0]       lag_reg;
    logic [31:0]       spos_reg;
    logic [SLOT_W-1:0] sslot_reg;
    logic [31:0]       sdrop_reg;
    logic [6:0]        take_reg;
    logic [6:0]        rem_reg;
    res_t              res_reg;
    logic              rd_valid_reg;
    logic              rd_last_reg;
    logic [7:0]        rdata_reg;

    logic [7:0] ring [RING_BYTES];

    logic [CIDX_W-1:0] cur_idx;
    logic [31:0]       cur_pos;
    logic [31:0]       cur_drop;
    logic [SLOT_W-1:0] cur_slot;
    logic [31:0]       lag_now;
    logic [31:0]       used_full;
    logic              over;
    logic [SLOT_W:0]   catch_sum;
    logic [SLOT_W:0]   catch_wrap;
    logic [SLOT_W-1:0] catch_slot;
    logic [31:0]       lag_eff;
    logic [6:0]        take_now;
    logic [2:0]        occ;
    logic              room;
    logic              rd_issue;
    logic              direct_push;
    logic              wb;
    logic              head_emit;
    res_t              res_init;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [31:0] pos,
                                                   input logic [SLOT_W-1:0] slot);
        // the slot tracks pos mod ring size, also across the 32-bit wrap
        if (pos == 32'hFFFF_FFFF || slot == SLOT_LAST) begin
            return '0;
        end
        return slot + 1'b1;
    endfunction

    assign cur_idx  = (state_reg == BK_IDLE) ? CIDX_W'(cq_head.cmd.id) : id_reg;
    assign cur_pos  = cpos_reg[cur_idx];
    assign cur_drop = cdrop_reg[cur_idx];
    assign cur_slot = cslot_reg[cur_idx];
    assign lag_now  = wp_reg - cur_pos;

    assign used_full = (wp_reg > RING_W32) ? RING_W32 : wp_reg;

    assign over       = lag_reg > RING_W32;
    assign catch_sum  = {1'b0, wslot_reg} + WRAP_REM_EXT;
    assign catch_wrap = catch_sum - RING_EXT;
    always_comb begin
        if (wp_reg >= RING_W32) begin
            catch_slot = wslot_reg;
        end else if (catch_sum >= RING_EXT) begin
            catch_slot = catch_wrap[SLOT_W-1:0];
        end else begin
            catch_slot = catch_sum[SLOT_W-1:0];
        end
    end
    assign lag_eff  = over ? RING_W32 : lag_reg;
    assign take_now = (lag_eff < {25'd0, maxb_reg}) ? lag_eff[6:0] : maxb_reg;

    assign occ  = {1'b0, ob_stat.level} + {2'b0, rd_valid_reg} - {2'b0, ob_stat.pop};
    assign room = occ < 3'(OB_DEPTH);

    // single result template: empty and last, stats fields only for stats
    always_comb begin
        res_init             = '0;
        res_init.last_of_run = 1'b1;
        if (cq_head.cmd.op == OP_STATS) begin
            res_init.used_bytes    = used_full[12:0];
            res_init.ring_capacity = 17'(RING_BYTES);
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (cq_head.valid) begin
                    case (cq_head.cmd.op)
                        OP_PULL:              state_next = BK_LAG;
                        OP_STATS, OP_BADPULL: state_next = BK_RESULT;
                        default:              state_next = BK_IDLE;
                    endcase
                end
            end
            BK_LAG: begin
                if (maxb_reg == 7'd0 || lag_now == 32'd0) begin
                    state_next = BK_RESULT;
                end else begin
                    state_next = BK_CATCH;
                end
            end
            BK_CATCH:  state_next = BK_STREAM;
            BK_STREAM: begin
                if (rem_reg == 7'd0) begin
                    state_next = BK_IDLE;
                end
            end
            BK_RESULT: begin
                if (direct_push) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        cq_pop      = (state_reg == BK_IDLE) && cq_head.valid;
        head_emit   = cq_pop && (cq_head.cmd.op == OP_EMIT);
        rd_issue    = (state_reg == BK_STREAM) && (rem_reg != 7'd0) && room;
        direct_push = (state_reg == BK_RESULT) && !rd_valid_reg && room;
        wb          = (state_reg == BK_STREAM) && (rem_reg == 7'd0);
        ob_push.push = rd_valid_reg || direct_push;
        if (rd_valid_reg) begin
            ob_push.res.byte_out      = rdata_reg;
            ob_push.res.byte_valid    = 1'b1;
            ob_push.res.last_of_run   = rd_last_reg;
            ob_push.res.taken_count   = take_reg;
            ob_push.res.drops_so_far  = sdrop_reg;
            ob_push.res.used_bytes    = '0;
            ob_push.res.ring_capacity = '0;
        end else begin
            ob_push.res = res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_IDLE;
            rd_valid_reg <= 1'b0;
            wp_reg       <= '0;
            wslot_reg    <= '0;
            for (int i = 0; i < NUM_CURSORS; i++) begin
                cpos_reg[i]  <= '0;
                cdrop_reg[i] <= '0;
                cslot_reg[i] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_issue;
            if (cq_pop) begin
                case (cq_head.cmd.op)
                    OP_EMIT: begin
                        wp_reg    <= wp_reg + 32'd1;
                        wslot_reg <= slot_inc(wp_reg, wslot_reg);
                    end
                    OP_SNAP: begin
                        cpos_reg[cur_idx]  <= wp_reg;
                        cdrop_reg[cur_idx] <= '0;
                        cslot_reg[cur_idx] <= wslot_reg;
                    end
                    OP_SKIP: begin
                        cdrop_reg[cur_idx] <= cur_drop + lag_now;
                        cpos_reg[cur_idx]  <= wp_reg;
                        cslot_reg[cur_idx] <= wslot_reg;
                    end
                    default: begin
                    end
                endcase
            end
            if (wb) begin
                cpos_reg[id_reg]  <= spos_reg;
                cslot_reg[id_reg] <= sslot_reg;
                cdrop_reg[id_reg] <= sdrop_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cq_pop) begin
            id_reg   <= CIDX_W'(cq_head.cmd.id);
            maxb_reg <= cq_head.cmd.maxb;
            res_reg  <= res_init;
        end
        if (state_reg == BK_LAG) begin
            lag_reg              <= lag_now;
            res_reg.drops_so_far <= cur_drop;
        end
        if (state_reg == BK_CATCH) begin
            // catch a lagging cursor up to the oldest byte still held
            sdrop_reg <= over ? cur_drop + (lag_reg - RING_W32) : cur_drop;
            spos_reg  <= over ? wp_reg - RING_W32 : cur_pos;
            sslot_reg <= over ? catch_slot : cur_slot;
            take_reg  <= take_now;
            rem_reg   <= take_now;
        end
        if (rd_issue) begin
            spos_reg    <= spos_reg + 32'd1;
            sslot_reg   <= slot_inc(spos_reg, sslot_reg);
            rem_reg     <= rem_reg - 7'd1;
            rd_last_reg <= (rem_reg == 7'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (head_emit) begin
            ring[wslot_reg] <= cq_head.cmd.data;
        end
        if (rd_issue) begin
            rdata_reg <= ring[sslot_reg];
        end
    end

endmodule

// ----- hw/rtl/rmor_obuf.sv -----
module rmor_obuf import rmor_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  ob_push_t ob_push,
    output ob_stat_t ob_stat,
    output logic     m_valid,
    input  logic     m_ready,
    output res_t     m_res
);

    res_t                ob_mem [OB_DEPTH];
    logic [OB_PTR_W-1:0] wr_ptr_reg;
    logic [OB_PTR_W-1:0] rd_ptr_reg;
    logic [1:0]          level_reg, level_next;
    logic                pop;

    assign m_valid       = (level_reg != 2'd0);
    assign m_res         = ob_mem[rd_ptr_reg];
    assign pop           = m_valid && m_ready;
    assign ob_stat.level = level_reg;
    assign ob_stat.pop   = pop;
    assign level_next    = level_reg + {1'b0, ob_push.push} - {1'b0, pop};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            level_reg <= level_next;
            if (ob_push.push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ob_push.push) begin
            ob_mem[wr_ptr_reg] <= ob_push.res;
        end
    end

endmodule

// ----- hw/rtl/multi_reader_overwrite_ring_top.sv -----
// Emit, snapshot, skip: one transfer per cycle with the back end idle, applied once popped from the queue.
// Stats: result passes the command queue, the result state and the result buffer; empty pulls also pass the lag check.
// Pull: lag check and catch-up, then one byte per cycle while the result buffer has room (ring read);
// after the last byte read is issued the back end writes the cursor back and takes the next command.
// Reset clears write position, cursors, drop counts and all queues at once;
// ring contents stay undefined until written and get no clearing pass.
module multi_reader_overwrite_ring_top import rmor_pkg::*; #(
    parameter int RING_BYTES  = RING_BYTES_DEF,
    parameter int NUM_CURSORS = NUM_CURSORS_DEF,
    parameter int MAX_PULL    = MAX_PULL_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_command,
    input  logic [7:0]  s_data_byte,
    input  logic [1:0]  s_cursor_id,
    input  logic [6:0]  s_max_bytes,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_byte_out,
    output logic        m_byte_valid,
    output logic        m_last_of_run,
    output logic [6:0]  m_taken_count,
    output logic [31:0] m_drops_so_far,
    output logic [12:0] m_used_bytes,
    output logic [16:0] m_ring_capacity
);

    // front -> back command queue head
    cq_head_t cq_head;
    logic     cq_pop;

    // back -> result buffer
    ob_push_t ob_push;
    ob_stat_t ob_stat;
    res_t     m_res;

    // Front: accept the transfer, classify it, hold it in a two-entry queue.
    rmor_front #(
        .NUM_CURSORS(NUM_CURSORS),
        .MAX_PULL   (MAX_PULL)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_command  (s_command),
        .s_data_byte(s_data_byte),
        .s_cursor_id(s_cursor_id),
        .s_max_bytes(s_max_bytes),
        .cq_head    (cq_head),
        .cq_pop     (cq_pop)
    );

    // Back: own the ring memory and cursors, execute one command at a time,
    // stream pulled bytes through a registered memory read.
    rmor_back #(
        .RING_BYTES (RING_BYTES),
        .NUM_CURSORS(NUM_CURSORS)
    ) u_back (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cq_head(cq_head),
        .cq_pop (cq_pop),
        .ob_stat(ob_stat),
        .ob_push(ob_push)
    );

    // Result buffer: decouple the result transfer from the back end.
    rmor_obuf u_obuf (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ob_push(ob_push),
        .ob_stat(ob_stat),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_res  (m_res)
    );

    assign m_byte_out      = m_res.byte_out;
    assign m_byte_valid    = m_res.byte_valid;
    assign m_last_of_run   = m_res.last_of_run;
    assign m_taken_count   = m_res.taken_count;
    assign m_drops_so_far  = m_res.drops_so_far;
    assign m_used_bytes    = m_res.used_bytes;
    assign m_ring_capacity = m_res.ring_capacity;

endmodule

// ----- hw/rtl/rmor_chk.sv -----
module rmor_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [2:0]  s_command,
    input logic [7:0]  s_data_byte,
    input logic [1:0]  s_cursor_id,
    input logic [6:0]  s_max_bytes,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_byte_out,
    input logic        m_byte_valid,
    input logic        m_last_of_run,
    input logic [6:0]  m_taken_count,
    input logic [31:0] m_drops_so_far,
    input logic [12:0] m_used_bytes,
    input logic [16:0] m_ring_capacity
);

    // hold a stalled input transfer
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=>
            s_valid && $stable(s_command) && $stable(s_data_byte) &&
            $stable(s_cursor_id) && $stable(s_max_bytes))
        else $error("input transfer changed while stalled");

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=>
            m_valid && $stable(m_byte_out) && $stable(m_byte_valid) &&
            $stable(m_last_of_run) && $stable(m_taken_count) &&
            $stable(m_drops_so_far) && $stable(m_used_bytes) &&
            $stable(m_ring_capacity))
        else $error("result dropped or changed while stalled");

    // a result without a byte is always the only one of its command
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_byte_valid |-> m_last_of_run)
        else $error("empty result not marked last");

    // a pulled byte carries a nonzero count and no stats
    a_byte_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_byte_valid |->
            m_taken_count != 7'd0 && m_used_bytes == 13'd0 && m_ring_capacity == 17'd0)
        else $error("pulled byte with bad side fields");

    // stats results carry no drop count and no byte
    a_stats_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ring_capacity != 17'd0 |->
            m_drops_so_far == 32'd0 && !m_byte_valid && m_taken_count == 7'd0)
        else $error("stats result with pull fields");

endmodule

bind multi_reader_overwrite_ring_top rmor_chk u_rmor_chk (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_command      (s_command),
    .s_data_byte    (s_data_byte),
    .s_cursor_id    (s_cursor_id),
    .s_max_bytes    (s_max_bytes),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_byte_out     (m_byte_out),
    .m_byte_valid   (m_byte_valid),
    .m_last_of_run  (m_last_of_run),
    .m_taken_count  (m_taken_count),
    .m_drops_so_far (m_drops_so_far),
    .m_used_bytes   (m_used_bytes),
    .m_ring_capacity(m_ring_capacity)
);

// ----- tb/sv/tb_multi_reader_overwrite_ring_top.sv -----
`timescale 1ns / 1ps

module tb_multi_reader_overwrite_ring_top;
    import rmor_pkg::*;

    localparam logic [31:0] RING       = RING_BYTES_DEF;
    localparam int          RING_AW    = $clog2(RING_BYTES_DEF);
    localparam int          NCUR       = NUM_CURSORS_DEF;
    localparam logic [6:0]  PULL_LIMIT = 7'(MAX_PULL_DEF);

    // Codes 5 to 7 carry no operation; the block must swallow them.
    localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

    // Longest stretch without any transfer before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 1000;
    // Cycles to keep watching the result port once nothing is outstanding.
    localparam int SETTLE_CYCLES  = 20;
    localparam int BURST_EMITS    = 70;
    localparam int RANDOM_ITEMS   = 370;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_command;
    logic [7:0]  s_data_byte;
    logic [1:0]  s_cursor_id;
    logic [6:0]  s_max_bytes;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_byte_out;
    logic        m_byte_valid;
    logic        m_last_of_run;
    logic [6:0]  m_taken_count;
    logic [31:0] m_drops_so_far;
    logic [12:0] m_used_bytes;
    logic [16:0] m_ring_capacity;

    // Shadow copy of the capture ring and the reader cursors.
    logic [7:0]  ring_image [RING];
    logic [31:0] wr_pos;
    logic [31:0] cur_pos   [NCUR];
    logic [31:0] cur_drops [NCUR];

    // Results still owed by the block, oldest first.
    res_t pending_results [$];

    bit idle_on      = 1'b1;
    int errors       = 0;
    int quiet_cycles = 0;

    multi_reader_overwrite_ring_top DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_data_byte     (s_data_byte),
        .s_cursor_id     (s_cursor_id),
        .s_max_bytes     (s_max_bytes),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_byte_out      (m_byte_out),
        .m_byte_valid    (m_byte_valid),
        .m_last_of_run   (m_last_of_run),
        .m_taken_count   (m_taken_count),
        .m_drops_so_far  (m_drops_so_far),
        .m_used_bytes    (m_used_bytes),
        .m_ring_capacity (m_ring_capacity)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Push one result onto the list of pending results.
    function automatic void owe_result(input logic [7:0] data, input logic vld,
                                       input logic last, input logic [6:0] taken,
                                       input logic [31:0] drops,
                                       input logic [12:0] used,
                                       input logic [16:0] cap);
        res_t r;
        r               = '0;
        r.byte_out      = data;
        r.byte_valid    = vld;
        r.last_of_run   = last;
        r.taken_count   = taken;
        r.drops_so_far  = drops;
        r.used_bytes    = used;
        r.ring_capacity = cap;
        pending_results.push_back(r);
    endfunction

    // Advance the shadow ring by one accepted command and record what it owes.
    function automatic void apply_command(input logic [2:0] cmd, input logic [7:0] data,
                                          input logic [1:0] id, input logic [6:0] maxb);
        logic [31:0] lag;
        logic [31:0] take;
        logic [31:0] used;
        logic [6:0]  lim;
        lag  = '0;
        take = '0;
        used = '0;
        lim  = (maxb > PULL_LIMIT) ? PULL_LIMIT : maxb;
        case (cmd)
            CMD_EMIT: begin
                ring_image[RING_AW'(wr_pos % RING)] = data;
                wr_pos = wr_pos + 32'd1;
            end
            CMD_SNAP: begin
                if (id < NCUR) begin
                    cur_pos[id]   = wr_pos;
                    cur_drops[id] = '0;
                end
            end
            CMD_PULL: begin
                if (id >= NCUR) begin
                    owe_result('0, 1'b0, 1'b1, '0, '0, '0, '0);
                end else if (lim == '0 || cur_pos[id] == wr_pos) begin
                    // nothing to take: one empty result, cursor untouched
                    owe_result('0, 1'b0, 1'b1, '0, cur_drops[id], '0, '0);
                end else begin
                    lag = wr_pos - cur_pos[id];
                    if (lag > RING) begin
                        // overrun: jump to the oldest byte still held
                        cur_drops[id] = cur_drops[id] + (lag - RING);
                        cur_pos[id]   = wr_pos - RING;
                        lag           = RING;
                    end
                    take = (lag < lim) ? lag : 32'(lim);
                    for (int i = 0; i < take; i++) begin
                        owe_result(ring_image[RING_AW'((cur_pos[id] + i) % RING)], 1'b1,
                                   (i + 1 == take), take[6:0], cur_drops[id], '0, '0);
                    end
                    cur_pos[id] = cur_pos[id] + take;
                end
            end
            CMD_SKIP: begin
                if (id < NCUR) begin
                    cur_drops[id] = cur_drops[id] + (wr_pos - cur_pos[id]);
                    cur_pos[id]   = wr_pos;
                end
            end
            CMD_STATS: begin
                used = (wr_pos > RING) ? RING : wr_pos;
                owe_result('0, 1'b0, 1'b1, '0, '0, used[12:0], RING[16:0]);
            end
            default: begin
            end
        endcase
    endfunction

    // Send one command: idle for a random gap while idling is on, then hold valid until the transfer.
    task automatic send_command(input logic [2:0] cmd, input logic [7:0] data,
                                input logic [1:0] id, input logic [6:0] maxb);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_data_byte <= data;
        s_cursor_id <= id;
        s_max_bytes <= maxb;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_command(cmd, data, id, maxb);
    endtask

    // Drop valid and hold off until every pending result has been seen.
    task automatic wait_for_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
            errors++;
        end
    endtask

    // Stats and pull straight out of reset: empty ring, cursor at the write position.
    task automatic test_reset_state();
        send_command(CMD_STATS, 8'($urandom), 2'($urandom), 7'($urandom));
        send_command(CMD_PULL, 8'($urandom), 2'd0, 7'd8);
    endtask

    // Byte extremes, zero and oversized limits, single byte pulls, last-of-run marking.
    task automatic test_pull_limits();
        send_command(CMD_EMIT, 8'h00, 2'($urandom), 7'($urandom));
        send_command(CMD_EMIT, 8'hFF, 2'($urandom), 7'($urandom));
        send_command(CMD_EMIT, 8'hA5, 2'($urandom), 7'($urandom));
        send_command(CMD_EMIT, 8'h5A, 2'($urandom), 7'($urandom));
        send_command(CMD_PULL, 8'($urandom), 2'd0, 7'd0);
        send_command(CMD_PULL, 8'($urandom), 2'd0, 7'd127);
        repeat (3) send_command(CMD_EMIT, 8'($urandom), 2'($urandom), 7'($urandom));
        send_command(CMD_PULL, 8'($urandom), 2'd1, 7'd1);
        send_command(CMD_PULL, 8'($urandom), 2'd1, 7'd64);
    endtask

    // Snapshot to now, caught-up pull, skip that counts the whole lag as dropped.
    task automatic test_snapshot_skip();
        send_command(CMD_SNAP, 8'($urandom), 2'd2, 7'($urandom));
        send_command(CMD_PULL, 8'($urandom), 2'd2, 7'd16);
        send_command(CMD_EMIT, 8'($urandom), 2'($urandom), 7'($urandom));
        send_command(CMD_EMIT, 8'($urandom), 2'($urandom), 7'($urandom));
        send_command(CMD_SKIP, 8'($urandom), 2'd3, 7'($urandom));
        send_command(CMD_PULL, 8'($urandom), 2'd3, 7'd4);
        send_command(CMD_SKIP, 8'($urandom), 2'd2, 7'($urandom));
        send_command(CMD_SNAP, 8'($urandom), 2'd3, 7'($urandom));
    endtask

    // Codes with no operation behind them give nothing back.
    task automatic test_unused_commands();
        for (logic [3:0] c = {1'b0, CMD_UNUSED_FIRST}; c <= {1'b0, CMD_UNUSED_LAST}; c++) begin
            send_command(c[2:0], 8'($urandom), 2'($urandom), 7'($urandom));
        end
        send_command(CMD_STATS, 8'($urandom), 2'($urandom), 7'($urandom));
    endtask

    // Back-to-back burst of emits, then full-size and short pulls on cursors that lag far behind.
    task automatic test_burst_pulls();
        idle_on = 1'b0;
        send_command(CMD_SNAP, 8'($urandom), 2'd2, 7'($urandom));
        repeat (BURST_EMITS) send_command(CMD_EMIT, 8'($urandom), 2'($urandom), 7'($urandom));
        idle_on = 1'b1;
        send_command(CMD_PULL, 8'($urandom), 2'd0, 7'd64);
        send_command(CMD_PULL, 8'($urandom), 2'd0, 7'd5);
        send_command(CMD_PULL, 8'($urandom), 2'd2, 7'd64);
        send_command(CMD_STATS, 8'($urandom), 2'($urandom), 7'($urandom));
        send_command(CMD_SKIP, 8'($urandom), 2'd1, 7'($urandom));
        send_command(CMD_PULL, 8'($urandom), 2'd1, 7'd5);
        send_command(CMD_SNAP, 8'($urandom), 2'd1, 7'($urandom));
        send_command(CMD_PULL, 8'($urandom), 2'd1, 7'd5);
    endtask

    // Weighted mix of all commands, idling switched in stretches, one drain pause.
    task automatic test_random_mix();
        int          sel;
        int          pick;
        logic [6:0]  maxb;
        logic [2:0]  cmd;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 60 == 0) idle_on = ($urandom_range(0, 2) != 0);
            if (i == RANDOM_ITEMS / 2) wait_for_drain();
            sel  = $urandom_range(0, 99);
            pick = $urandom_range(0, 19);
            if (pick == 0)      maxb = 7'd0;
            else if (pick == 1) maxb = 7'($urandom_range(64, 127));
            else                maxb = 7'($urandom_range(1, 16));
            if (sel < 45)      cmd = CMD_EMIT;
            else if (sel < 70) cmd = CMD_PULL;
            else if (sel < 80) cmd = CMD_SNAP;
            else if (sel < 88) cmd = CMD_SKIP;
            else if (sel < 95) cmd = CMD_STATS;
            else               cmd = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
            send_command(cmd, 8'($urandom), 2'($urandom), maxb);
        end
        idle_on = 1'b1;
    endtask

    initial begin
        s_valid     = 1'b0;
        s_command   = CMD_EMIT;
        s_data_byte = '0;
        s_cursor_id = '0;
        s_max_bytes = '0;
        aresetn     = 1'b0;
        wr_pos      = '0;
        for (int c = 0; c < NCUR; c++) begin
            cur_pos[c]   = '0;
            cur_drops[c] = '0;
        end
        // Hold reset, release between edges.
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_pull_limits();
        test_snapshot_skip();
        test_unused_commands();
        test_burst_pulls();
        test_random_mix();

        // Stop sending, wait out every owed result, then watch for strays.
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (errors == 0) begin
            $display("tb_multi_reader_overwrite_ring_top OK");
        end else begin
            $display("tb_multi_reader_overwrite_ring_top NOT OK");
        end
        $finish;
    end

    // Result side: stall at random while idling is on, then take one transfer
    // and compare it with the oldest pending result.
    initial begin : result_monitor
        res_t want;
        int   stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = idle_on ? $urandom_range(0, 4) : 0;
            repeat (stall) begin
                @(negedge aclk);
                m_ready <= 1'b0;
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            @(posedge aclk);
            while (m_valid !== 1'b1) @(posedge aclk);
            if (pending_results.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual byte %0d valid %0b",
                         $time, m_byte_out, m_byte_valid);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("byte_out",      32'(want.byte_out),      32'(m_byte_out));
                check_field("byte_valid",    32'(want.byte_valid),    32'(m_byte_valid));
                check_field("last_of_run",   32'(want.last_of_run),   32'(m_last_of_run));
                check_field("taken_count",   32'(want.taken_count),   32'(m_taken_count));
                check_field("drops_so_far",  want.drops_so_far,       m_drops_so_far);
                check_field("used_bytes",    32'(want.used_bytes),    32'(m_used_bytes));
                check_field("ring_capacity", 32'(want.ring_capacity), 32'(m_ring_capacity));
            end
        end
    end

    // Watchdog: end the run when neither side has moved a transfer for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_multi_reader_overwrite_ring_top NOT OK");
            $finish;
        end
    end

endmodule
